/* design/xor_frame_receiver_unit_assert.svh */
// Assertion macros used by the frame receiver top level.
`ifndef XOR_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define XOR_FRAME_RECEIVER_UNIT_ASSERT_SVH

// lbl: whenever ante holds, cons holds in the same cycle
`define XFR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// lbl: whenever ante holds, cons holds in the next cycle
`define XFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

/* design/xfr_pkg.sv */
// Types and constants of the sync/type/length frame receiver.
package xfr_pkg;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_TYPE = 3'd1,
      PH_LENL = 3'd2,
      PH_LENH = 3'd3,
      PH_DATA = 3'd4,
      PH_CSUM = 3'd5
   } xfr_phase_type;

   localparam logic [7:0]  CSR_SYNC_VALUE  = 8'd0;
   localparam logic [7:0]  CSR_MAX_LEN     = 8'd1;
   localparam logic [7:0]  SYNC_VALUE_RST  = 8'hAA;
   localparam logic [15:0] MAX_LEN_RST     = 16'd1100;

   typedef struct packed {
      logic [7:0]  sync_value;
      logic [15:0] max_len;
   } xfr_cfg_type;

   typedef struct packed {
      logic        emit;
      logic        is_end;
      logic [7:0]  data;
      logic [15:0] byte_index;
      logic [7:0]  frame_type;
      logic [15:0] frame_len;
      logic        checksum_ok;
   } xfr_result_type;

endpackage

/* design/xfr_parse.sv */
// Frame parser state and per-byte result logic.
module xfr_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              in_byte,
   input  xfr_pkg::xfr_cfg_type    cfg,
   output xfr_pkg::xfr_result_type result
);

   xfr_pkg::xfr_phase_type phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] len_full;
   logic [15:0] count_next;

   assign len_full   = {in_byte, len_ff[7:0]};
   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      count_in = count_ff;
      xor_in   = xor_ff;
      result            = '0;
      result.frame_type = type_ff;
      result.frame_len  = len_ff;
      unique case (phase_ff)
         xfr_pkg::PH_TYPE: begin
            type_in  = in_byte;
            xor_in   = xor_ff ^ in_byte;
            phase_in = xfr_pkg::PH_LENL;
         end
         xfr_pkg::PH_LENL: begin
            len_in   = {8'd0, in_byte};
            xor_in   = xor_ff ^ in_byte;
            phase_in = xfr_pkg::PH_LENH;
         end
         xfr_pkg::PH_LENH: begin
            len_in   = len_full;
            xor_in   = xor_ff ^ in_byte;
            count_in = 16'd0;
            if (len_full > cfg.max_len) begin
               phase_in = xfr_pkg::PH_HUNT;
            end else if (len_full == 16'd0) begin
               phase_in = xfr_pkg::PH_CSUM;
            end else begin
               phase_in = xfr_pkg::PH_DATA;
            end
         end
         xfr_pkg::PH_DATA: begin
            result.emit       = 1'b1;
            result.data       = in_byte;
            result.byte_index = count_ff;
            xor_in   = xor_ff ^ in_byte;
            count_in = count_next;
            if (count_next >= len_ff) begin
               phase_in = xfr_pkg::PH_CSUM;
            end
         end
         xfr_pkg::PH_CSUM: begin
            result.emit        = 1'b1;
            result.is_end      = 1'b1;
            result.checksum_ok = (xor_ff == in_byte);
            phase_in = xfr_pkg::PH_HUNT;
         end
         default: begin
            if (in_byte == cfg.sync_value) begin
               phase_in = xfr_pkg::PH_TYPE;
               xor_in   = 8'd0;
            end else begin
               phase_in = xfr_pkg::PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xfr_pkg::PH_HUNT;
         type_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

endmodule

/* design/xor_frame_receiver_unit.sv */
// Top level of the sync/type/length/XOR-checksum frame receiver.
//
// Usage:
//  - req channel: one received link byte per request (req_in_byte).
//  - rsp channel: one result per payload byte (rsp_is_end = 0) and one
//    end-of-frame result per checksum byte (rsp_is_end = 1, rsp_checksum_ok).
//    Sync, type and length bytes, and frames whose length exceeds max_len,
//    give no result. Commit a payload only on an end result with a good check.
//  - csr channel: index 0 sync_value, index 1 max_len; always ready, other
//    indexes ignored. Write only while no request is in flight.
//  - Datapath: a request is registered in the input register, parsed
//    combinationally, and its result is registered in the result register.
//  - Throughput: one request per cycle while no result stalls, set by the single
//    parse stage between the input register and the result register.
//  - Stall: while rsp_ready is low a pending result holds; one more request
//    is taken into the input register, then req_ready drops.
//  - Reset: parser returns to hunting for sync, registers take their reset
//    values (0xAA, 1100), both stages empty.
module xor_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_end,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_byte_index,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_len,
   output logic        rsp_checksum_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

`include "xor_frame_receiver_unit_assert.svh"

   xfr_pkg::xfr_cfg_type    cfg_ff;
   xfr_pkg::xfr_result_type result;
   xfr_pkg::xfr_result_type out_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic       step;

   assign step         = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || step;
   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !step);
   assign out_valid_in = step ? result.emit : (out_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;

   xfr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         cfg_ff.sync_value <= xfr_pkg::SYNC_VALUE_RST;
         cfg_ff.max_len    <= xfr_pkg::MAX_LEN_RST;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end else begin
            in_valid_ff <= in_valid_ff;
         end
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_index == xfr_pkg::CSR_SYNC_VALUE) begin
            cfg_ff.sync_value <= csr_data[7:0];
         end
         if (csr_valid && csr_index == xfr_pkg::CSR_MAX_LEN) begin
            cfg_ff.max_len <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (step && result.emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_is_end      = out_ff.is_end;
   assign rsp_data        = out_ff.data;
   assign rsp_byte_index  = out_ff.byte_index;
   assign rsp_frame_type  = out_ff.frame_type;
   assign rsp_frame_len   = out_ff.frame_len;
   assign rsp_checksum_ok = out_ff.checksum_ok;

   `XFR_ASSERT_IMPLY(a_end_fields_zero, clock, reset, rsp_valid && rsp_is_end,
      rsp_data == 8'd0 && rsp_byte_index == 16'd0)
   `XFR_ASSERT_IMPLY(a_payload_no_check, clock, reset, rsp_valid && !rsp_is_end,
      !rsp_checksum_ok && rsp_byte_index < rsp_frame_len)
   `XFR_ASSERT_IMPLY(a_no_step_on_stall, clock, reset, out_valid_ff && !rsp_ready,
      !step)
   `XFR_ASSERT_NEXT(a_stall_holds_request, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_ready, in_valid_ff && $stable(in_byte_ff))

endmodule
